@@ design/lir_pkg.sv @@
`default_nettype none

package lir_pkg;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 5;
    localparam int TICK_W     = 9;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ROM_DEPTH  = 32;

    // Action codes on the input side
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FALL    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RX_BYTE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

    // Phase codes as seen on the result
    localparam logic [PHASE_W-1:0] PHASE_LISTEN  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_COMMAND = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_PENDING = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_READY   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_APERTURE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] APERTURE_RESET = 8'd20;
    localparam logic [BYTE_W-1:0] READY_RESET    = 8'd4;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 9'd256;

    // Start command from the body
    localparam logic [BYTE_W-1:0] START_CMD = 8'h44;

    // Identity frame; entries past the defined ones read as zero
    localparam logic [BYTE_W-1:0] FRAME_ROM [ROM_DEPTH] = '{
        8'd37, 8'd20, 8'd80, 8'd0,  8'd96, 8'd248, 8'd17, 8'd12,
        8'd6,  8'd0,  8'd26, 8'd20, 8'd0,  8'd32,  8'd0,  8'd0,
        8'd80, 8'd20, 8'd15, 8'd88, 8'd80, 8'd80,  8'd20, 8'd20,
        8'd5,  8'd20, 8'd0,  8'd0,  8'd0,  8'd0,   8'd0,  8'd0
    };

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   rx_byte;
    } item_t;

    typedef struct packed {
        logic               line_pulled_low;
        logic               tx_load;
        logic [BYTE_W-1:0]  tx_byte;
        logic [PHASE_W-1:0] phase_now;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // Frame entry with the aperture code patched in, bit order reversed for
    // the LSB-first shifter
    function automatic logic [BYTE_W-1:0] frame_byte(
        input logic [INDEX_W-1:0] idx,
        input logic [BYTE_W-1:0]  aperture
    );
        logic [BYTE_W-1:0] raw;
        logic [BYTE_W-1:0] flipped;
        if (idx == 5'd1 || idx == 5'd17 || idx == 5'd25)
            raw = aperture;
        else
            raw = FRAME_ROM[idx];
        for (int k = 0; k < BYTE_W; k++)
            flipped[BYTE_W-1-k] = raw[k];
        return flipped;
    endfunction

endpackage

`default_nettype wire

@@ design/lir_in_stage.sv @@
`default_nettype none

// Input register: holds one accepted item until the engine takes it
module lir_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lir_pkg::item_t  in_item,
    input  wire logic            take,
    output logic                 item_valid,
    output lir_pkg::item_t       item
);
    import lir_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ design/lir_engine.sv @@
`default_nettype none

// Phase sequencer, timers, configuration registers and frame lookup
module lir_engine #(
    parameter int FRAME_BYTES = 26
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lir_pkg::cfg_write_t cfg,
    input  wire lir_pkg::item_t     item,
    input  wire logic               fire,
    output lir_pkg::result_t        result
);
    import lir_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        LISTEN  = PHASE_LISTEN,
        COMMAND = PHASE_COMMAND,
        PENDING = PHASE_PENDING,
        READY   = PHASE_READY
    } phase_t;

    localparam logic [INDEX_W:0] FRAME_END = (INDEX_W+1)'(FRAME_BYTES);

    logic [BYTE_W-1:0]  aperture_reg;
    logic [BYTE_W-1:0]  ready_delay_reg;
    logic [TICK_W-1:0]  idle_timeout_reg;

    phase_t             phase_reg, phase_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               line_reg, line_next;

    logic               load;
    logic [INDEX_W-1:0] load_index;
    logic [TICK_W-1:0]  limit_raw;
    logic [TICK_W-1:0]  limit;
    logic [TICK_W-1:0]  tick_inc;
    logic [INDEX_W:0]   index_inc;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aperture_reg     <= APERTURE_RESET;
            ready_delay_reg  <= READY_RESET;
            idle_timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                CFG_APERTURE: aperture_reg     <= cfg.data[BYTE_W-1:0];
                CFG_READY:    ready_delay_reg  <= cfg.data[BYTE_W-1:0];
                CFG_TIMEOUT:  idle_timeout_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // Timer limit: ready delay while pending, idle timeout otherwise; zero acts as one
    assign limit_raw = (phase_reg == PENDING) ? {1'b0, ready_delay_reg} : idle_timeout_reg;
    assign limit     = (limit_raw == '0) ? TICK_W'(1) : limit_raw;
    assign tick_inc  = tick_reg + TICK_W'(1);
    assign index_inc = {1'b0, index_reg} + (INDEX_W+1)'(1);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        tick_next  = tick_reg;
        line_next  = line_reg;
        load       = 1'b0;
        load_index = '0;

        unique case (item.action)
            ACT_TICK:
            begin
                if (phase_reg != LISTEN)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= limit)
                    begin
                        if (phase_reg == PENDING)
                        begin
                            line_next  = 1'b1;
                            phase_next = READY;
                            tick_next  = '0;
                        end
                        else
                        begin
                            phase_next = LISTEN;
                            index_next = '0;
                            tick_next  = '0;
                            line_next  = 1'b0;
                        end
                    end
                end
            end
            ACT_FALL:
            begin
                if (phase_reg == LISTEN)
                begin
                    line_next  = 1'b1;
                    phase_next = COMMAND;
                    tick_next  = '0;
                end
            end
            ACT_RX_BYTE:
            begin
                if (phase_reg == COMMAND)
                begin
                    if (item.rx_byte == START_CMD)
                    begin
                        index_next = '0;
                        load       = 1'b1;
                        load_index = '0;
                        line_next  = 1'b0;
                        tick_next  = '0;
                        phase_next = PENDING;
                    end
                    else
                    begin
                        phase_next = LISTEN;
                        index_next = '0;
                        tick_next  = '0;
                        line_next  = 1'b0;
                    end
                end
                else if (phase_reg == PENDING || phase_reg == READY)
                begin
                    line_next = 1'b0;
                    if (index_inc < FRAME_END && !index_inc[INDEX_W])
                    begin
                        index_next = index_inc[INDEX_W-1:0];
                        load       = 1'b1;
                        load_index = index_inc[INDEX_W-1:0];
                        tick_next  = '0;
                        phase_next = PENDING;
                    end
                    else
                    begin
                        // end of frame
                        phase_next = LISTEN;
                        index_next = '0;
                        tick_next  = '0;
                    end
                end
            end
            ACT_UNUSED: ;
            default:    ;
        endcase
    end

    // State update on each item that moves on to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LISTEN;
            index_reg <= '0;
            tick_reg  <= '0;
            line_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            tick_reg  <= tick_next;
            line_reg  <= line_next;
        end
    end

    // Result of this item
    assign result.line_pulled_low = line_next;
    assign result.tx_load         = load;
    assign result.tx_byte         = load ? frame_byte(load_index, aperture_reg) : '0;
    assign result.phase_now       = phase_next;

endmodule

`default_nettype wire

@@ design/lir_out_stage.sv @@
`default_nettype none

// Result register: holds a finished result until the sink takes it
module lir_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire lir_pkg::result_t result,
    output logic                  fire,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lir_pkg::result_t      out_result
);
    import lir_pkg::*;

    logic    valid_reg;
    result_t result_reg;
    logic    advance;

    assign advance    = !valid_reg || out_ready;
    assign fire       = item_valid && advance;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ design/lens_identity_responder.sv @@
// Path from an input transfer to its result on the master side: input
// register, then result register, with the phase logic between them.
// Throughput: one item per cycle while the master side is not stalled.
// Reset (rst_n low, asynchronous): listen phase, line released, timer and
// frame index cleared, registers back to aperture 20, delay 4, timeout 256.
`default_nettype none

module lens_identity_responder #(
    parameter int FRAME_BYTES = 26
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [0] line_pulled_low, [8:1] tx_byte,
                                             // [10:9] phase_now, [15:11] zero
    output logic             m_axis_tuser    // [0] tx_load
);
    import lir_pkg::*;

    cfg_write_t cfg;
    item_t      in_item;
    item_t      item;
    logic       item_valid;
    logic       fire;
    result_t    result;
    result_t    out_result;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign in_item.action  = s_axis_tuser;
    assign in_item.rx_byte = s_axis_tdata;

    lir_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    lir_engine #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .fire   (fire),
        .result (result)
    );

    lir_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .fire       (fire),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {5'd0, out_result.phase_now, out_result.tx_byte,
                           out_result.line_pulled_low};
    assign m_axis_tuser = out_result.tx_load;

endmodule

`default_nettype wire

@@ design/lir_checker.sv @@
`default_nettype none

module lir_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    import lir_pkg::*;

    logic [PHASE_W-1:0] phase_seen;
    logic               line_seen;

    assign phase_seen = m_axis_tdata[10:9];
    assign line_seen  = m_axis_tdata[0];

    // No result is offered in the cycle after reset is sampled low
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // A stalled result keeps its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A byte load always leaves the block pending with the line released
    a_load_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> phase_seen == PHASE_PENDING && !line_seen)
        else $error("load outside byte-pending phase");

    // Line is held low exactly in the command and byte-ready phases
    a_line_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            line_seen == (phase_seen == PHASE_COMMAND || phase_seen == PHASE_READY))
        else $error("line state disagrees with phase");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0)
        else $error("nonzero padding in result");

endmodule

bind lens_identity_responder lir_port_checker u_lir_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/lir_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the register port, predicts every reply of the
// responder and compares it with what comes out of the master side.
module lir_checker
    import lir_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,   // [0] line_pulled_low, [8:1] tx_byte,
                                             // [10:9] phase_now, [15:11] zero
    input  wire logic        m_axis_tuser,   // [0] tx_load
    output int               error_count,
    output int               pending_count
);

    localparam int LENS_FRAME_LEN = 26;

    // Shadow registers
    logic [BYTE_W-1:0]  reg_aperture;
    logic [BYTE_W-1:0]  reg_delay;
    logic [TICK_W-1:0]  reg_timeout;

    // Shadow responder state
    logic [PHASE_W-1:0] resp_phase;
    logic [INDEX_W-1:0] resp_index;
    logic [TICK_W-1:0]  resp_ticks;
    logic               resp_line_low;

    result_t awaited_replies[$];
    int      errs = 0;

    function automatic logic [BYTE_W-1:0] mirror_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++)
            r[BYTE_W-1-k] = v[k];
        return r;
    endfunction

    // Frame entry as it goes to the shifter: aperture patched in, bits reversed
    function automatic logic [BYTE_W-1:0] lens_tx_code(input logic [INDEX_W-1:0] idx);
        logic [BYTE_W-1:0] raw;
        if (idx == 5'd1 || idx == 5'd17 || idx == 5'd25)
            raw = reg_aperture;
        else
            raw = FRAME_ROM[idx];
        return mirror_byte(raw);
    endfunction

    task automatic drop_to_listen();
        resp_phase    = PHASE_LISTEN;
        resp_index    = '0;
        resp_ticks    = '0;
        resp_line_low = 1'b0;
    endtask

    // One event in, one reply out
    task automatic respond_to_event(
        input  logic [ACTION_W-1:0] act,
        input  logic [BYTE_W-1:0]   rx,
        output result_t             reply
    );
        logic [TICK_W-1:0] limit;
        logic [5:0]        nxt;
        reply = '0;
        case (act)
            ACT_TICK: begin
                if (resp_phase != PHASE_LISTEN) begin
                    limit = (resp_phase == PHASE_PENDING) ? {1'b0, reg_delay} : reg_timeout;
                    if (limit == '0)
                        limit = 9'd1;
                    resp_ticks = resp_ticks + 9'd1;
                    if (resp_ticks >= limit) begin
                        if (resp_phase == PHASE_PENDING) begin
                            resp_line_low = 1'b1;
                            resp_phase    = PHASE_READY;
                            resp_ticks    = '0;
                        end
                        else
                            drop_to_listen();
                    end
                end
            end
            ACT_FALL: begin
                if (resp_phase == PHASE_LISTEN) begin
                    resp_line_low = 1'b1;
                    resp_phase    = PHASE_COMMAND;
                    resp_ticks    = '0;
                end
            end
            ACT_RX_BYTE: begin
                if (resp_phase == PHASE_COMMAND) begin
                    if (rx == START_CMD) begin
                        resp_index    = '0;
                        reply.tx_byte = lens_tx_code('0);
                        reply.tx_load = 1'b1;
                        resp_line_low = 1'b0;
                        resp_ticks    = '0;
                        resp_phase    = PHASE_PENDING;
                    end
                    else
                        drop_to_listen();
                end
                else if (resp_phase == PHASE_PENDING || resp_phase == PHASE_READY) begin
                    nxt = {1'b0, resp_index} + 6'd1;
                    resp_line_low = 1'b0;
                    if (nxt < LENS_FRAME_LEN) begin
                        resp_index    = nxt[INDEX_W-1:0];
                        reply.tx_byte = lens_tx_code(resp_index);
                        reply.tx_load = 1'b1;
                        resp_ticks    = '0;
                        resp_phase    = PHASE_PENDING;
                    end
                    else
                        drop_to_listen();
                end
            end
            default: ;
        endcase
        reply.line_pulled_low = resp_line_low;
        reply.phase_now       = resp_phase;
    endtask

    // Compare one reply transfer with the oldest prediction
    task automatic check_reply();
        result_t want;
        if (awaited_replies.size() == 0) begin
            $error("reply transfer with nothing expected: tdata %h tuser %b",
                   m_axis_tdata, m_axis_tuser);
            errs++;
            return;
        end
        want = awaited_replies.pop_front();
        if (m_axis_tdata[0] !== want.line_pulled_low) begin
            $error("line_pulled_low: expected %0d, got %0d", want.line_pulled_low, m_axis_tdata[0]);
            errs++;
        end
        if (m_axis_tuser !== want.tx_load) begin
            $error("tx_load: expected %0d, got %0d", want.tx_load, m_axis_tuser);
            errs++;
        end
        if (m_axis_tdata[8:1] !== want.tx_byte) begin
            $error("tx_byte: expected %h, got %h", want.tx_byte, m_axis_tdata[8:1]);
            errs++;
        end
        if (m_axis_tdata[10:9] !== want.phase_now) begin
            $error("phase_now: expected %0d, got %0d", want.phase_now, m_axis_tdata[10:9]);
            errs++;
        end
        if (m_axis_tdata[15:11] !== 5'd0) begin
            $error("tdata padding: expected 0, got %h", m_axis_tdata[15:11]);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t reply;
        if (!rst_n) begin
            reg_aperture = APERTURE_RESET;
            reg_delay    = READY_RESET;
            reg_timeout  = TIMEOUT_RESET;
            drop_to_listen();
            awaited_replies.delete();
        end
        else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_APERTURE: reg_aperture = cfg_data[7:0];
                    CFG_READY:    reg_delay    = cfg_data[7:0];
                    CFG_TIMEOUT:  reg_timeout  = cfg_data;
                    default: ;
                endcase
            end
            // accepted events
            if (s_axis_tvalid && s_axis_tready) begin
                respond_to_event(s_axis_tuser, s_axis_tdata, reply);
                awaited_replies.push_back(reply);
            end
            // reply transfers
            if (m_axis_tvalid && m_axis_tready)
                check_reply();
        end
        pending_count <= awaited_replies.size();
        error_count   <= errs;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import lir_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
    logic [1:0]  s_axis_tuser = '0;   // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [0] line_pulled_low, [8:1] tx_byte,
                                      // [10:9] phase_now, [15:11] zero
    logic        m_axis_tuser;        // [0] tx_load

    int fail_count;
    int pending;
    int cycle_count = 0;
    int events_sent = 0;

    // Receiver control
    bit quiet = 1'b0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    // What the stimulus last wrote, for shaping sequences
    int delay_sh = 4;
    int timeout_sh = 256;

    lens_identity_responder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lir_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (fail_count),
        .pending_count (pending)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (holds_asked != holds_served)
        begin
            holds_served  <= holds_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet || ($urandom_range(99) >= 9);
    end

    // One transfer on the input side, with random gaps ahead of it when not quiet
    task automatic send_event(input logic [1:0] act, input logic [7:0] rx);
        if (!quiet)
        begin
            while ($urandom_range(99) < 9)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= rx;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act != ACT_UNUSED)
            events_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_event(ACT_TICK, 8'($urandom_range(255)));
    endtask

    // Let every reply come back, then idle before returning
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on back-to-back cycles
    task automatic load_settings(input logic [7:0] ap, input logic [7:0] dl, input logic [8:0] to);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_APERTURE;
        cfg_data  <= {1'b0, ap};
        @(posedge clk);
        cfg_index <= CFG_READY;
        cfg_data  <= {1'b0, dl};
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= to;
        @(posedge clk);
        cfg_we    <= 1'b0;
        delay_sh   = dl;
        timeout_sh = to;
    endtask

    // One handshake session: mostly well formed, sometimes broken or pure noise
    task automatic run_session();
        int eff_delay;
        int eff_timeout;
        int nbytes;
        int mode;
        logic [7:0] cmd;
        eff_delay   = (delay_sh == 0) ? 1 : delay_sh;
        eff_timeout = (timeout_sh == 0) ? 1 : timeout_sh;
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 6))
                send_event(2'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        send_event(ACT_FALL, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0)
            send_ticks($urandom_range(0, (eff_timeout < 8) ? eff_timeout : 8));
        if ($urandom_range(99) < 12)
        begin
            cmd = 8'($urandom_range(255));
            if (cmd == START_CMD)
                cmd ^= 8'h01;
            send_event(ACT_RX_BYTE, cmd);
            return;
        end
        send_event(ACT_RX_BYTE, START_CMD);
        if (eff_delay > 20)
            nbytes = $urandom_range(0, 2);
        else if ($urandom_range(99) < 30)
            nbytes = 26;
        else
            nbytes = $urandom_range(0, 27);
        for (int b = 0; b < nbytes; b++)
        begin
            mode = $urandom_range(99);
            if (mode < 70)
                send_ticks(eff_delay);
            else if (mode < 90 || eff_timeout > 40)
                send_ticks($urandom_range(0, eff_delay - 1));
            else
                send_ticks(eff_delay + eff_timeout);
            if ($urandom_range(99) < 5)
                send_event($urandom_range(1) ? ACT_UNUSED : ACT_FALL, 8'($urandom_range(255)));
            send_event(ACT_RX_BYTE, 8'($urandom_range(255)));
        end
        // walk back to listen through the timers where that is cheap
        if (eff_timeout <= 40 && $urandom_range(1) == 1)
            send_ticks(eff_delay + eff_timeout);
    endtask

    task automatic run_sessions(input int budget);
        int start;
        start = events_sent;
        while (events_sent - start < budget)
            run_session();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings (aperture 20, delay 4, timeout 256)
        send_event(ACT_TICK, 8'h00);        // tick while listening
        send_event(ACT_RX_BYTE, 8'h00);     // byte while listening
        send_event(ACT_UNUSED, 8'hFF);      // unused code
        send_event(ACT_FALL, 8'h00);        // enter command
        send_event(ACT_FALL, 8'hAA);        // edge outside listen
        send_event(ACT_RX_BYTE, 8'h45);     // wrong command
        send_event(ACT_FALL, 8'h00);
        send_event(ACT_RX_BYTE, START_CMD); // entry 0
        send_event(ACT_RX_BYTE, 8'hFF);     // byte while pending, aperture entry
        send_ticks(4);                      // reach byte ready
        send_event(ACT_UNUSED, 8'h12);
        send_event(ACT_RX_BYTE, 8'h00);     // byte while ready
        send_event(ACT_TICK, 8'h55);
        send_event(ACT_FALL, 8'h00);
        send_event(ACT_RX_BYTE, 8'h80);
        send_ticks(2);
        settle();

        // Smallest timers and a zero aperture code
        load_settings(8'd0, 8'd1, 9'd1);
        run_sessions(20);
        settle();

        // Zero delay and timeout act as one
        load_settings(8'd255, 8'd0, 9'd0);
        run_sessions(20);
        settle();

        // No idling on either side
        load_settings(8'hA5, 8'd2, 9'd9);
        quiet <= 1'b1;
        run_sessions(40);
        quiet <= 1'b0;
        settle();

        // Long receiver hold-off while events keep coming
        load_settings(8'($urandom_range(255)), 8'($urandom_range(1, 6)),
                      9'($urandom_range(5, 40)));
        holds_asked <= holds_asked + 1;
        run_sessions(30);
        settle();

        // Largest timers: one full delay, then a full timeout from byte ready
        load_settings(8'h5A, 8'd255, 9'd256);
        send_event(ACT_FALL, 8'h00);
        send_event(ACT_RX_BYTE, START_CMD);
        send_ticks(255);
        send_ticks(256);
        settle();

        // Random settings with a long timeout
        load_settings(8'($urandom_range(255)), 8'($urandom_range(1, 8)),
                      9'($urandom_range(41, 256)));
        run_sessions(20);
        settle();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
